@@ design/tsc_pkg.sv @@
// shared widths, register indexes and reset values for the touch calibration block
package tsc_pkg;

   localparam int ADC_BITS   = 12;
   localparam int COORD_BITS = 10;
   localparam int SAMPLES    = 4;
   localparam int NUM_CH     = 4;
   localparam int SIZE_W     = 11;

   localparam int REQ_DATA_W = 2 * NUM_CH * ADC_BITS;
   localparam int RSP_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = ADC_BITS;

   typedef logic [ADC_BITS-1:0]   adc_type;
   typedef logic [SIZE_W-1:0]     size_type;
   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam csr_addr_type REG_X_LOW         = 3'd0;
   localparam csr_addr_type REG_X_HIGH        = 3'd1;
   localparam csr_addr_type REG_Y_LOW         = 3'd2;
   localparam csr_addr_type REG_Y_HIGH        = 3'd3;
   localparam csr_addr_type REG_SCREEN_WIDTH  = 3'd4;
   localparam csr_addr_type REG_SCREEN_HEIGHT = 3'd5;

   localparam adc_type  RST_X_LOW         = 12'd506;
   localparam adc_type  RST_X_HIGH        = 12'd3217;
   localparam adc_type  RST_Y_LOW         = 12'd618;
   localparam adc_type  RST_Y_HIGH        = 12'd3592;
   localparam size_type RST_SCREEN_WIDTH  = 11'd240;
   localparam size_type RST_SCREEN_HEIGHT = 11'd320;

endpackage

@@ design/touch_sample_calibrate.sv @@
// resistive touch poll averaging and two-point calibration to screen coordinates
//
//  port group   dir  word contents
//  req_*        in   tuser: touched; tdata: x samples 0..3 then y samples 0..3
//  rsp_*        out  tuser: pressed; tdata: pos_x then pos_y, zero padded
//  csr_*        in   write enable, register index, write data (no read-back)
//
// a touched poll passes, per axis, through the shared 12x11 multiplier, the shared
// restoring divider (one quotient bit a cycle) and the saturation state, then through
// the done state into the output register
// a released poll skips the arithmetic and goes from idle straight to the done state
// req_tready is high only while the sequencer is idle, so a new poll is taken only
// once the previous one has left its done state; a finished word waits in the
// output register until rsp_tready, and while the previous word still waits there
// the sequencer holds in its done state
// synchronous active-high reset clears the sequencer, held coordinates and output
// valid, and restores the calibration registers
module touch_sample_calibrate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tsc_pkg::REQ_DATA_W-1:0] req_tdata,  // x_sample_0..3, y_sample_0..3
   input  logic                          req_tuser,  // touched
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tsc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // pos_x, pos_y, zero fill
   output logic                          rsp_tuser,  // pressed
   input  logic                          csr_we,
   input  logic [tsc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tsc_pkg::*;

   localparam int PROD_W = ADC_BITS + SIZE_W;   // product of offset and screen size
   localparam int QUO_W  = SIZE_W;              // quotient never exceeds screen size
   localparam int REM_W  = ADC_BITS;
   localparam int CNT_W  = $clog2(QUO_W + 1);
   localparam int SUM_W  = ADC_BITS + 2;
   localparam int SV_W   = SIZE_W + 2;          // signed width for the inverted y term
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);
   localparam coord_type COORD_MAX = {COORD_BITS{1'b1}};

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_SAT  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // configuration
   adc_type  x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   size_type width_ff, height_ff;

   // sequencer and operands
   logic [2:0]       state_ff, state_in;
   logic             touched_ff, touched_in;
   logic             axis_ff, axis_in;          // 0 x, 1 y
   adc_type          ax_ff, ax_in, ay_ff, ay_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] dvd_ff, dvd_in;            // dividend bits still to shift in
   logic [QUO_W-1:0] quo_ff, quo_in;
   adc_type          den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   coord_type        new_x_ff, new_x_in, new_y_ff, new_y_in;
   coord_type        held_x_ff, held_x_in, held_y_ff, held_y_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pressed_ff, rsp_pressed_in;
   coord_type        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // datapath nets
   logic             req_fire, out_free;
   logic [SUM_W-1:0] sum_x, sum_y;
   adc_type          op_a, op_lo, op_hi, a_clamp, span;
   size_type         op_size, top_raw;
   coord_type        top;
   logic             zero_span;
   logic [PROD_W-1:0] prod;
   logic [REM_W:0]   part;
   logic             take;
   logic signed [SV_W-1:0] y_val;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_pressed_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*COORD_BITS){1'b0}}, rsp_y_ff, rsp_x_ff};

   // averaging of the first SAMPLES readings per axis
   always_comb begin
      sum_x = '0;
      sum_y = '0;
      for (int i = 0; i < SAMPLES; i++) begin
         sum_x = sum_x + SUM_W'(req_tdata[i*ADC_BITS +: ADC_BITS]);
         sum_y = sum_y + SUM_W'(req_tdata[(NUM_CH + i)*ADC_BITS +: ADC_BITS]);
      end
   end

   // shared operand selection, clamp and multiplier
   always_comb begin
      op_a    = axis_ff ? ay_ff     : ax_ff;
      op_lo   = axis_ff ? y_low_ff  : x_low_ff;
      op_hi   = axis_ff ? y_high_ff : x_high_ff;
      op_size = axis_ff ? height_ff : width_ff;
      // raise to low first, then lower to high
      a_clamp = (op_a < op_lo) ? op_lo : op_a;
      a_clamp = (a_clamp > op_hi) ? op_hi : a_clamp;
      zero_span = (op_hi <= op_lo);
      span      = op_hi - op_lo;
      prod      = zero_span ? '0 : PROD_W'(a_clamp - op_lo) * PROD_W'(op_size);
   end

   // one restoring division step
   always_comb begin
      part = {rem_ff, dvd_ff[QUO_W-1]};
      take = (part >= {1'b0, den_ff});
   end

   // saturation limits
   always_comb begin
      top_raw = (op_size == '0) ? '0 : op_size - 1'b1;
      top     = (top_raw > SIZE_W'(COORD_MAX)) ? COORD_MAX : top_raw[COORD_BITS-1:0];
      y_val   = $signed({2'b00, op_size}) - $signed(SV_W'(1)) - $signed({2'b00, quo_ff});
   end

   always_comb begin
      state_in       = state_ff;
      touched_in     = touched_ff;
      axis_in        = axis_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      rem_in         = rem_ff;
      dvd_in         = dvd_ff;
      quo_in         = quo_ff;
      den_in         = den_ff;
      cnt_in         = cnt_ff;
      new_x_in       = new_x_ff;
      new_y_in       = new_y_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               touched_in = req_tuser;
               ax_in      = ADC_BITS'(sum_x / SAMPLES);
               ay_in      = ADC_BITS'(sum_y / SAMPLES);
               axis_in    = 1'b0;
               state_in   = req_tuser ? S_MUL : S_DONE;
            end
         end
         S_MUL: begin
            // quotient fits QUO_W bits, so the top part is already below the divisor
            rem_in   = prod[PROD_W-1 -: REM_W];
            dvd_in   = prod[QUO_W-1:0];
            den_in   = zero_span ? ADC_BITS'(1) : span;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = take ? REM_W'(part - {1'b0, den_ff}) : part[REM_W-1:0];
            dvd_in = {dvd_ff[QUO_W-2:0], 1'b0};
            quo_in = {quo_ff[QUO_W-2:0], take};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            if (!axis_ff) begin
               new_x_in = (quo_ff > {1'b0, top}) ? top : quo_ff[COORD_BITS-1:0];
               axis_in  = 1'b1;
               state_in = S_MUL;
            end else begin
               if (y_val < 0) begin
                  new_y_in = '0;
               end else if (y_val > $signed(SV_W'(top))) begin
                  new_y_in = top;
               end else begin
                  new_y_in = y_val[COORD_BITS-1:0];
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pressed_in = touched_ff;
               if (touched_ff) begin
                  held_x_in = new_x_ff;
                  held_y_in = new_y_ff;
                  rsp_x_in  = new_x_ff;
                  rsp_y_in  = new_y_ff;
               end else begin
                  rsp_x_in  = held_x_ff;
                  rsp_y_in  = held_y_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= RST_X_LOW;
         x_high_ff <= RST_X_HIGH;
         y_low_ff  <= RST_Y_LOW;
         y_high_ff <= RST_Y_HIGH;
         width_ff  <= RST_SCREEN_WIDTH;
         height_ff <= RST_SCREEN_HEIGHT;
      end else if (csr_we) begin
         case (csr_addr)
            REG_X_LOW:         x_low_ff  <= csr_wdata[ADC_BITS-1:0];
            REG_X_HIGH:        x_high_ff <= csr_wdata[ADC_BITS-1:0];
            REG_Y_LOW:         y_low_ff  <= csr_wdata[ADC_BITS-1:0];
            REG_Y_HIGH:        y_high_ff <= csr_wdata[ADC_BITS-1:0];
            REG_SCREEN_WIDTH:  width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      touched_ff     <= touched_in;
      axis_ff        <= axis_in;
      ax_ff          <= ax_in;
      ay_ff          <= ay_in;
      rem_ff         <= rem_in;
      dvd_ff         <= dvd_in;
      quo_ff         <= quo_in;
      den_ff         <= den_in;
      cnt_ff         <= cnt_in;
      new_x_ff       <= new_x_in;
      new_y_ff       <= new_y_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
   end

   // divider remainder stays below the divisor throughout the division
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   // divisor is never zero while dividing
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (den_ff != '0))
      else $error("zero divisor in divider");

   // a released poll skips the arithmetic
   a_release_skip: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser) |=> (state_ff == S_DONE))
      else $error("released poll entered the arithmetic");

   // a released word carries the held coordinates
   a_release_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free && !touched_ff)
      |=> (rsp_x_ff == $past(held_x_ff) && rsp_y_ff == $past(held_y_ff)))
      else $error("released word lost the held coordinates");

endmodule
